/* rtl/mst_pkg.sv */
// Shared types, constants and command/status structs for the master-stack tiler.
package mst_pkg;

   // Request and geometry limits
   localparam int MAX_WINDOWS     = 64;
   localparam int RATIO_FRAC_BITS = 16;

   localparam int COUNT_W = 7;
   localparam int MC_W    = 8;
   localparam int INDEX_W = 6;
   localparam int COORD_W = 16;
   localparam int AREA_W  = 14;
   localparam int POS_W   = 15;
   localparam int GAP_W   = 10;
   localparam int RATIO_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Divider: dividend is ah - (n - 1) * gap, divisor is a row count
   localparam int DIVIDEND_W = 18;
   localparam int MAG_W      = 17;
   localparam int DIVISOR_W  = 7;

   // Register reset values
   localparam logic [AREA_W-1:0]  AREA_WIDTH_RST  = 14'd1920;
   localparam logic [AREA_W-1:0]  AREA_HEIGHT_RST = 14'd1080;
   localparam logic [RATIO_W-1:0] RATIO_RST       = 16'd32768;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AREA_X      = 3'd0,
      CSR_AREA_Y      = 3'd1,
      CSR_AREA_WIDTH  = 3'd2,
      CSR_AREA_HEIGHT = 3'd3,
      CSR_INNER_GAP   = 3'd4,
      CSR_OUTER_GAP   = 3'd5,
      CSR_SPLIT_RATIO = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [COUNT_W-1:0]     window_count;
      logic signed [MC_W-1:0] lead_count;
   } req_item_type;

   typedef struct packed {
      logic [INDEX_W-1:0]        window_index;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] rect_width;
      logic signed [COORD_W-1:0] rect_height;
      logic                      last;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MULT,
      ST_DIVM_GO,
      ST_DIVM_WAIT,
      ST_SETUP_M,
      ST_EMIT_M,
      ST_DIVS_GO,
      ST_DIVS_WAIT,
      ST_SETUP_S,
      ST_EMIT_S
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic mult;
      logic div_m;
      logic div_s;
      logic setup_m;
      logic setup_s;
      logic emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic empty;
      logic has_stack;
      logic div_done;
      logic row_last;
   } status_type;

endpackage

/* rtl/mst_div.sv */
// Restoring divider: signed dividend by positive row count, one quotient bit per cycle.
module mst_div
   import mst_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]         divisor,
   output logic                         done,
   output logic signed [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(MAG_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MAG_W - 1);

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic                  neg_ff, neg_in;
   logic [CNT_W-1:0]      step_ff, step_in;
   logic [MAG_W-1:0]      q_ff, q_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic [DIVIDEND_W-1:0] abs_dividend;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // Load the operands on start, else one restoring step while running
   always_comb begin
      abs_dividend = dividend[DIVIDEND_W-1] ? -dividend : dividend;
      shifted = {rem_ff, q_ff[MAG_W-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};

      run_in  = run_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      step_in = step_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         run_in  = 1'b1;
         neg_in  = dividend[DIVIDEND_W-1];
         step_in = '0;
         q_in    = abs_dividend[MAG_W-1:0];
         rem_in  = '0;
         den_in  = divisor;
      end else if (run_ff) begin
         q_in    = {q_ff[MAG_W-2:0], fits};
         rem_in  = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // Hold working values
   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      step_ff <= step_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   // Truncate toward zero: apply the dividend's sign to the magnitude
   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});

   // A new division never starts over a running one
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !run_ff)
      else $error("divider restarted while running");

endmodule

/* rtl/mst_dp.sv */
// Datapath: configuration registers, geometry arithmetic, row divider and rectangle stepping.
module mst_dp
   import mst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_item_type          req_item,
   input  cmd_type               cmd,
   output status_type            status,
   output rsp_item_type          rsp_item
);

   localparam int PROD_W = AREA_W + RATIO_W;

   // Configuration registers
   logic signed [POS_W-1:0] area_x_ff, area_y_ff;
   logic [AREA_W-1:0]       area_width_ff, area_height_ff;
   logic [GAP_W-1:0]        inner_gap_ff, outer_gap_ff;
   logic [RATIO_W-1:0]      ratio_ff;

   // Request and geometry registers
   logic [COUNT_W-1:0]        cnt_ff, cnt_in;
   logic [COUNT_W-1:0]        mc_ff, mc_in;
   logic signed [COORD_W-1:0] ax_ff, ay_ff, aw_ff, ah_ff;
   logic signed [COORD_W-1:0] ax_in, ay_in, aw_in, ah_in;
   logic [COORD_W-1:0]        mw_raw_ff, gap_m_ff, gap_s_ff;
   logic signed [COORD_W-1:0] mw_ff, sw_ff, mw_in, sw_in;

   // Emit registers
   logic [INDEX_W-1:0]        idx_ff;
   logic [COUNT_W-1:0]        rows_ff;
   logic signed [COORD_W-1:0] x_ff, y_ff, w_ff, h_ff, step_ff;

   logic [COUNT_W-1:0]           stack;
   logic [PROD_W-1:0]            prod;
   logic [COUNT_W+GAP_W-1:0]     gap_m_full, gap_s_full;
   logic [COORD_W-1:0]           half_gap;
   logic                         div_start;
   logic signed [DIVIDEND_W-1:0] dividend, quotient;
   logic [DIVISOR_W-1:0]         divisor;
   logic                         div_done;
   logic signed [COORD_W-1:0]    quo16;
   logic [COUNT_W-1:0]           idx_ext;

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         area_x_ff      <= '0;
         area_y_ff      <= '0;
         area_width_ff  <= AREA_WIDTH_RST;
         area_height_ff <= AREA_HEIGHT_RST;
         inner_gap_ff   <= '0;
         outer_gap_ff   <= '0;
         ratio_ff       <= RATIO_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_AREA_X:       area_x_ff      <= csr_wdata[POS_W-1:0];
            CSR_AREA_Y:       area_y_ff      <= csr_wdata[POS_W-1:0];
            CSR_AREA_WIDTH:   area_width_ff  <= csr_wdata[AREA_W-1:0];
            CSR_AREA_HEIGHT:  area_height_ff <= csr_wdata[AREA_W-1:0];
            CSR_INNER_GAP:    inner_gap_ff   <= csr_wdata[GAP_W-1:0];
            CSR_OUTER_GAP:    outer_gap_ff   <= csr_wdata[GAP_W-1:0];
            CSR_SPLIT_RATIO:  ratio_ff       <= csr_wdata[RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   // Saturate count, clamp master count, shrink area by the outer gap
   always_comb begin
      cnt_in = (req_item.window_count > COUNT_W'(MAX_WINDOWS)) ?
               COUNT_W'(MAX_WINDOWS) : req_item.window_count;
      if (req_item.lead_count < 8'sd1)
         mc_in = COUNT_W'(1);
      else if (req_item.lead_count > $signed({1'b0, cnt_in}))
         mc_in = cnt_in;
      else
         mc_in = req_item.lead_count[COUNT_W-1:0];
      ax_in = COORD_W'(area_x_ff) + $signed({6'b0, outer_gap_ff});
      ay_in = COORD_W'(area_y_ff) + $signed({6'b0, outer_gap_ff});
      aw_in = $signed({2'b0, area_width_ff}) - $signed({5'b0, outer_gap_ff, 1'b0});
      ah_in = $signed({2'b0, area_height_ff}) - $signed({5'b0, outer_gap_ff, 1'b0});
   end

   assign stack    = cnt_ff - mc_ff;
   assign half_gap = {7'b0, inner_gap_ff[GAP_W-1:1]};

   // Master width product and row gap totals
   assign prod       = aw_ff[AREA_W-1:0] * ratio_ff;
   assign gap_m_full = (mc_ff - 1'b1) * inner_gap_ff;
   assign gap_s_full = (stack - 1'b1) * inner_gap_ff;

   // Column widths; with a stack each column gives up half the inner gap at the split
   always_comb begin
      if (stack != '0) begin
         mw_in = $signed(mw_raw_ff - half_gap);
         sw_in = aw_ff - $signed(mw_raw_ff) - $signed(half_gap);
      end else begin
         mw_in = aw_ff;
         sw_in = '0;
      end
   end

   // Feed the row divider
   assign div_start = cmd.div_m | cmd.div_s;
   assign divisor   = cmd.div_s ? stack : mc_ff;
   assign dividend  = $signed({2'b0, ah_ff}) -
                      $signed({2'b0, cmd.div_s ? gap_s_ff : gap_m_ff});

   mst_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   assign quo16 = quotient[COORD_W-1:0];

   // Latch request and geometry
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cnt_ff <= cnt_in;
         mc_ff  <= mc_in;
         ax_ff  <= ax_in;
         ay_ff  <= ay_in;
         aw_ff  <= aw_in;
         ah_ff  <= ah_in;
      end
      if (cmd.mult) begin
         mw_raw_ff <= COORD_W'(prod[PROD_W-1:RATIO_FRAC_BITS]);
         gap_m_ff  <= gap_m_full[COORD_W-1:0];
         gap_s_ff  <= gap_s_full[COORD_W-1:0];
      end
      if (cmd.div_m) begin
         mw_ff <= mw_in;
         sw_ff <= sw_in;
      end
   end

   // Set up a column, then advance one row per emitted item
   always_ff @(posedge clock) begin
      if (cmd.load)
         idx_ff <= '0;
      else if (cmd.emit)
         idx_ff <= idx_ff + 1'b1;

      if (cmd.setup_m || cmd.setup_s) begin
         h_ff    <= quo16;
         step_ff <= quo16 + $signed({6'b0, inner_gap_ff});
         y_ff    <= ay_ff;
      end else if (cmd.emit) begin
         y_ff <= y_ff + step_ff;
      end

      if (cmd.setup_m) begin
         x_ff    <= ax_ff;
         w_ff    <= mw_ff;
         rows_ff <= mc_ff;
      end else if (cmd.setup_s) begin
         x_ff    <= ax_ff + mw_ff + $signed({6'b0, inner_gap_ff});
         w_ff    <= sw_ff;
         rows_ff <= stack;
      end else if (cmd.emit) begin
         rows_ff <= rows_ff - 1'b1;
      end
   end

   assign idx_ext = {1'b0, idx_ff};

   // Status to the controller
   always_comb begin
      status.empty     = (cnt_ff == '0) || aw_ff[COORD_W-1] || (aw_ff == '0) ||
                         ah_ff[COORD_W-1] || (ah_ff == '0);
      status.has_stack = stack != '0;
      status.div_done  = div_done;
      status.row_last  = rows_ff == COUNT_W'(1);
   end

   // Result item
   always_comb begin
      rsp_item.window_index = idx_ff;
      rsp_item.pos_x        = x_ff;
      rsp_item.pos_y        = y_ff;
      rsp_item.rect_width   = w_ff;
      rsp_item.rect_height  = h_ff;
      rsp_item.last         = idx_ext == (cnt_ff - 1'b1);
   end

   // Every emitted row comes from a column with rows left
   a_rows_left: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> rows_ff != '0)
      else $error("row emitted past end of column");

endmodule

/* rtl/mst_ctrl.sv */
// Controller: load, empty check, multiply, master divide/emit, then stack if any.
module mst_ctrl
   import mst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_strobe
);

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.empty ? ST_IDLE : ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_DIVM_GO;
         end
         ST_DIVM_GO: begin
            cmd.div_m = 1'b1;
            state_in  = ST_DIVM_WAIT;
         end
         ST_DIVM_WAIT: begin
            if (status.div_done)
               state_in = ST_SETUP_M;
         end
         ST_SETUP_M: begin
            cmd.setup_m = 1'b1;
            state_in    = ST_EMIT_M;
         end
         ST_EMIT_M: begin
            cmd.emit = 1'b1;
            if (status.row_last)
               state_in = status.has_stack ? ST_DIVS_GO : ST_IDLE;
         end
         ST_DIVS_GO: begin
            cmd.div_s = 1'b1;
            state_in  = ST_DIVS_WAIT;
         end
         ST_DIVS_WAIT: begin
            if (status.div_done)
               state_in = ST_SETUP_S;
         end
         ST_SETUP_S: begin
            cmd.setup_s = 1'b1;
            state_in    = ST_EMIT_S;
         end
         ST_EMIT_S: begin
            cmd.emit = 1'b1;
            if (status.row_last)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = cmd.emit;

   // An accepted item always goes to the empty check next
   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start) |=> state_ff == ST_CHECK)
      else $error("accepted item did not reach the empty check");

   // The stack run ends the item
   a_stack_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_S && status.row_last) |=> state_ff == ST_IDLE)
      else $error("stack run did not end the item");

endmodule

/* rtl/master_stack_tiler.sv */
// Top level: master-stack tiler, one rectangle per window, up to 64 per request.
// Rectangles follow the master row division, one per cycle for the master column,
// then the stack column's rectangles after its own row division. Each division runs
// through the serial 17-step row divider; a request is taken only while idle.
// Requests with no windows or an empty area give no rectangles.
// Reset (synchronous): idle, CSRs at their defaults; results cannot be stalled.
module master_stack_tiler
   import mst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_item_type          req_item,
   output logic                  rsp_strobe,
   output rsp_item_type          rsp_item,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   mst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   mst_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_item  (rsp_item)
   );

endmodule

/* bench/tb_master_stack_tiler.sv */
// Testbench for master_stack_tiler: directed and random requests checked against a tiling model.

// Mirrors the tiler registers, predicts the rectangles of each accepted
// request and checks every emitted rectangle against the oldest one owed.
class tiling_scoreboard;
   logic signed [mst_pkg::POS_W-1:0] area_x;
   logic signed [mst_pkg::POS_W-1:0] area_y;
   logic [mst_pkg::AREA_W-1:0]        area_width;
   logic [mst_pkg::AREA_W-1:0]        area_height;
   logic [mst_pkg::GAP_W-1:0]         inner_gap;
   logic [mst_pkg::GAP_W-1:0]         outer_gap;
   logic [mst_pkg::RATIO_W-1:0]       split_ratio;
   mst_pkg::rsp_item_type             pending_rects[$];
   int                                mismatches;

   function new();
      area_x       = '0;
      area_y       = '0;
      area_width   = mst_pkg::AREA_WIDTH_RST;
      area_height  = mst_pkg::AREA_HEIGHT_RST;
      inner_gap    = '0;
      outer_gap    = '0;
      split_ratio  = mst_pkg::RATIO_RST;
      mismatches   = 0;
   endfunction

   // Keep only the bits each register holds; other indexes have no register
   function void set_register(logic [mst_pkg::CSR_IDX_W-1:0] idx,
                              logic [mst_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         mst_pkg::CSR_AREA_X:       area_x       = data[mst_pkg::POS_W-1:0];
         mst_pkg::CSR_AREA_Y:       area_y       = data[mst_pkg::POS_W-1:0];
         mst_pkg::CSR_AREA_WIDTH:   area_width   = data[mst_pkg::AREA_W-1:0];
         mst_pkg::CSR_AREA_HEIGHT:  area_height  = data[mst_pkg::AREA_W-1:0];
         mst_pkg::CSR_INNER_GAP:    inner_gap    = data[mst_pkg::GAP_W-1:0];
         mst_pkg::CSR_OUTER_GAP:    outer_gap    = data[mst_pkg::GAP_W-1:0];
         mst_pkg::CSR_SPLIT_RATIO:  split_ratio  = data[mst_pkg::RATIO_W-1:0];
         default: ;
      endcase
   endfunction

   // Wrap the geometry to the 16-bit output fields
   function mst_pkg::rsp_item_type make_rect(longint k, longint x, longint y,
                                             longint w, longint h, bit is_last);
      mst_pkg::rsp_item_type r;
      r.window_index = k[mst_pkg::INDEX_W-1:0];
      r.pos_x        = x[mst_pkg::COORD_W-1:0];
      r.pos_y        = y[mst_pkg::COORD_W-1:0];
      r.rect_width   = w[mst_pkg::COORD_W-1:0];
      r.rect_height  = h[mst_pkg::COORD_W-1:0];
      r.last         = is_last;
      return r;
   endfunction

   // Lay out one request: master column first, then the stack column
   function void note_request(mst_pkg::req_item_type it);
      longint count, masters, stack, gi, go;
      longint ax, ay, aw, ah, mw, sw, mh, sh, sx, k;
      count = longint'(it.window_count);
      if (count > mst_pkg::MAX_WINDOWS)
         count = mst_pkg::MAX_WINDOWS;
      if (count == 0)
         return;
      gi = longint'(inner_gap);
      go = longint'(outer_gap);
      ax = longint'(area_x) + go;
      ay = longint'(area_y) + go;
      aw = longint'(area_width) - 2 * go;
      ah = longint'(area_height) - 2 * go;
      if (aw <= 0 || ah <= 0)
         return;
      masters = longint'($signed(it.lead_count));
      if (masters < 1)
         masters = 1;
      if (masters > count)
         masters = count;
      stack = count - masters;
      if (stack > 0)
         mw = (aw * longint'(split_ratio)) >> mst_pkg::RATIO_FRAC_BITS;
      else
         mw = aw;
      sw = aw - mw;
      if (stack > 0) begin
         mw -= gi / 2;
         sw -= gi / 2;
      end
      mh = (ah - (masters - 1) * gi) / masters;
      k = 0;
      for (longint i = 0; i < masters; i++) begin
         pending_rects.push_back(make_rect(k, ax, ay + i * (mh + gi), mw, mh, k == count - 1));
         k++;
      end
      if (stack > 0) begin
         sx = ax + mw + gi;
         sh = (ah - (stack - 1) * gi) / stack;
         for (longint i = 0; i < stack; i++) begin
            pending_rects.push_back(make_rect(k, sx, ay + i * (sh + gi), sw, sh,
                                              k == count - 1));
            k++;
         end
      end
   endfunction

   task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 100)
         $display("[%0t] ERROR: %s", $time, what);
   endtask

   // Compare one emitted rectangle with the oldest one owed
   task check_rect(mst_pkg::rsp_item_type got);
      mst_pkg::rsp_item_type want;
      if (pending_rects.size() == 0) begin
         report_mismatch($sformatf("rectangle %0d emitted with none owed", got.window_index));
         return;
      end
      want = pending_rects.pop_front();
      if (got.window_index !== want.window_index)
         report_mismatch($sformatf("window_index got %0d want %0d",
                                   got.window_index, want.window_index));
      if (got.pos_x !== want.pos_x)
         report_mismatch($sformatf("rect %0d pos_x got %0d want %0d",
                                   want.window_index, got.pos_x, want.pos_x));
      if (got.pos_y !== want.pos_y)
         report_mismatch($sformatf("rect %0d pos_y got %0d want %0d",
                                   want.window_index, got.pos_y, want.pos_y));
      if (got.rect_width !== want.rect_width)
         report_mismatch($sformatf("rect %0d rect_width got %0d want %0d",
                                   want.window_index, got.rect_width, want.rect_width));
      if (got.rect_height !== want.rect_height)
         report_mismatch($sformatf("rect %0d rect_height got %0d want %0d",
                                   want.window_index, got.rect_height, want.rect_height));
      if (got.last !== want.last)
         report_mismatch($sformatf("rect %0d last got %0b want %0b",
                                   want.window_index, got.last, want.last));
   endtask

   task check_drained();
      if (pending_rects.size() != 0)
         report_mismatch($sformatf("%0d rectangles never emitted", pending_rects.size()));
   endtask
endclass

module tb_master_stack_tiler;
   timeunit 1ns;
   timeprecision 1ps;
   import mst_pkg::*;

   // Index with no register behind it; writes must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int DRAIN_CYCLES = 128;
   localparam int CYCLE_LIMIT  = 400000;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_item_type          req_item;
   logic                  rsp_strobe;
   rsp_item_type          rsp_item;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tiling_scoreboard sb;
   int               cycle_count = 0;

   master_stack_tiler uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Check every rectangle in the cycle it is shown
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         sb.check_rect(rsp_item);
   end

   // Hold start until the tiler takes the request, then idle at random
   task send_request(input int wc, input int mc, input bit allow_idle);
      req_item_type it;
      it.window_count = wc[COUNT_W-1:0];
      it.lead_count   = mc[MC_W-1:0];
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      sb.note_request(it);
      if (allow_idle && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         case ($urandom_range(0, 2))
            1: do @(posedge clock); while (busy);
            2: begin
               if (sb.pending_rects.size() != 0)
                  do @(posedge clock); while (rsp_strobe !== 1'b1);
            end
            default: ;
         endcase
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Drop start, wait for every owed rectangle, then let the tiler go quiet
   task settle();
      start <= 1'b0;
      while (sb.pending_rects.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.set_register(idx, data);
      @(posedge clock);
   endtask

   task apply_settings(input logic [15:0] x, input logic [15:0] y, input logic [15:0] w,
                       input logic [15:0] h, input logic [15:0] ig, input logic [15:0] og,
                       input logic [15:0] ratio);
      settle();
      write_reg(CSR_AREA_X, x);
      write_reg(CSR_AREA_Y, y);
      write_reg(CSR_AREA_WIDTH, w);
      write_reg(CSR_AREA_HEIGHT, h);
      write_reg(CSR_INNER_GAP, ig);
      write_reg(CSR_OUTER_GAP, og);
      write_reg(CSR_SPLIT_RATIO, ratio);
      write_reg(CSR_UNUSED, 16'($urandom));
      csr_we <= 1'b0;
   endtask

   // Half the time a screen-like area with modest gaps, else raw register noise
   task random_settings();
      logic [15:0] w, h, ig, og;
      if ($urandom_range(0, 1) == 0) begin
         w  = 16'($urandom_range(100, 4000));
         h  = 16'($urandom_range(100, 3000));
         ig = 16'($urandom_range(0, 40));
         og = 16'($urandom_range(0, 40));
      end else begin
         w  = 16'($urandom);
         h  = 16'($urandom);
         ig = 16'($urandom);
         og = 16'($urandom);
      end
      apply_settings(16'($urandom), 16'($urandom), w, h, ig, og, 16'($urandom));
   endtask

   // Mostly small layouts with sensible master counts, some saturating or odd ones
   task random_requests(input int n, input bit allow_idle);
      int wc, mc, pick, cap;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 6)
            wc = 0;
         else if (pick < 70)
            wc = $urandom_range(1, 8);
         else if (pick < 92)
            wc = $urandom_range(9, 64);
         else
            wc = $urandom_range(65, 127);
         cap  = (wc > MAX_WINDOWS) ? MAX_WINDOWS : wc;
         pick = $urandom_range(0, 99);
         if (pick < 65)
            mc = $urandom_range(1, cap + 1);
         else if (pick < 85)
            mc = $urandom_range(0, 255);
         else
            mc = -int'($urandom_range(0, 3));
         send_request(wc, mc, allow_idle);
      end
   endtask

   initial begin
      sb = new();
      reset     <= 1'b1;
      start     <= 1'b0;
      req_item  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset layout: empty, single, saturated and clamped requests
      send_request(0, 0, 1);
      send_request(1, 0, 1);
      send_request(1, -128, 1);
      send_request(2, 1, 1);
      send_request(5, 2, 1);
      send_request(64, 1, 1);
      send_request(64, 64, 1);
      send_request(127, 127, 1);
      send_request(100, -1, 1);
      send_request(7, 127, 1);
      send_request(3, 3, 1);

      // Extreme corner, full-size area and widest gap: coordinates wrap
      apply_settings(16'hC000, 16'h3FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
      send_request(64, 32, 1);
      send_request(2, 1, 1);
      send_request(1, 1, 1);
      send_request(10, -5, 1);

      // Outer gap eats the whole height
      apply_settings(16'h3FFF, 16'h4000, 16'd2047, 16'd2046, 16'd1, 16'd1023, 16'd0);
      send_request(4, 2, 1);
      send_request(1, 1, 1);

      // One pixel wide, odd inner gap, zero ratio: a negative master width
      apply_settings(16'd0, 16'd0, 16'd2047, 16'd2048, 16'd3, 16'd1023, 16'd0);
      send_request(3, 1, 1);
      send_request(2, 1, 1);

      // No height at all
      apply_settings(16'd0, 16'd0, 16'd100, 16'd0, 16'd0, 16'd0, 16'd40000);
      send_request(1, 1, 1);

      // Inner gap far larger than the area: negative row heights
      apply_settings(16'd0, 16'd0, 16'd500, 16'd10, 16'd1000, 16'd0, 16'd40000);
      send_request(64, 40, 1);
      send_request(9, 3, 1);

      // Random phases, the last one without idling
      for (int phase = 0; phase < 6; phase++) begin
         random_settings();
         random_requests(75, phase != 5);
      end

      settle();
      sb.check_drained();
      if (sb.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

/* filelist.f */
rtl/mst_pkg.sv
rtl/mst_div.sv
rtl/mst_dp.sv
rtl/mst_ctrl.sv
rtl/master_stack_tiler.sv
bench/tb_master_stack_tiler.sv
